FILE: hdl/mlr_pkg.sv
// ---------------------------------------------------------------------------
// Mono linear resampler package
// Shared constants and the types that connect the sequencer to the shared
// subtract/compare unit.
// ---------------------------------------------------------------------------
package mlr_pkg;

    localparam int RATE_W     = 18;
    localparam int PHASE_W    = 15;
    localparam int SKIP_W     = 4;
    localparam int SUB_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [RATE_W-1:0]  RATE_MIN   = 18'd4000;
    localparam logic [RATE_W-1:0]  RATE_MAX   = 18'd192000;
    localparam logic [RATE_W-1:0]  RATE_RESET = 18'd48000;
    localparam logic [PHASE_W-1:0] TGT_LO     = 15'd16000;
    localparam logic [PHASE_W-1:0] TGT_HI     = 15'd24000;
    localparam logic [SKIP_W-1:0]  SKIP_MAX   = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SELECT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE   = 2'd2;

    typedef struct packed {
        logic [SUB_W-1:0] a;
        logic [SUB_W-1:0] b;
    } sub_req_t;

    typedef struct packed {
        logic [SUB_W-1:0] diff;
        logic             ge;
    } sub_res_t;

endpackage

FILE: hdl/mlr_sub_unit.sv
// ---------------------------------------------------------------------------
// Shared subtract/compare unit
// Computes a - b and whether a >= b. Serves both the bit-serial divider and
// the phase advance loop.
// ---------------------------------------------------------------------------
module mlr_sub_unit
    import mlr_pkg::*;
(
    input  sub_req_t req,
    output sub_res_t res
);

    logic [SUB_W:0] wide;

    assign wide     = {1'b0, req.a} - {1'b0, req.b};
    assign res.diff = wide[SUB_W-1:0];
    assign res.ge   = ~wide[SUB_W];

endmodule

FILE: hdl/mono_linear_resampler_core.sv
// ---------------------------------------------------------------------------
// Mono linear resampler core
// Folds stereo frames to mono (left sample only in mono mode) and resamples them
// by linear interpolation to 16 kHz or 24 kHz, one frame at a time under a small sequencer.
// ---------------------------------------------------------------------------
// One frame is taken at a time; s_ready is high only while the sequencer is
// idle. Each interpolated result runs the bit-serial divider and then the
// phase loop, which subtracts the target rate from the phase once per step;
// a result repeated at the end of a stream runs only the phase loop. The
// divider and the phase loop take turns on one 18-bit subtractor, and the
// interpolation numerator is formed by a multiply-accumulate in states
// ST_MUL1 and ST_MUL2. Waiting on m_ready for the result word adds to the
// time a frame costs. Configuration writes are taken at any time and must
// only be issued while idle.
module mono_linear_resampler_core
    import mlr_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] s_right_sample,
    input  logic                         s_stream_last,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_sample,
    output logic                         m_run_last,
    output logic                         m_stream_end
);

    localparam int SB    = SAMPLE_BITS;
    localparam int NUM_W = SB + 16;
    localparam int CNT_W = $clog2(SB);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PEND, ST_LOOP, ST_MUL1, ST_MUL2, ST_DSET, ST_DIV, ST_ADV0,
        ST_ADV1, ST_PLACE, ST_UPD, ST_LPEND, ST_LLOOP, ST_LPLACE, ST_FIN
    } state_t;

    function automatic logic confirmed(input logic [SKIP_W-1:0] skip,
                                       input logic [PHASE_W-1:0] rem,
                                       input logic [SKIP_W-1:0] limit);
        return (skip < limit) || (skip == limit && rem == '0);
    endfunction

    state_t state_reg, state_next;

    logic [RATE_W-1:0]    src_reg, src_next;
    logic                 tsel_reg, tsel_next;
    logic                 stereo_reg, stereo_next;

    logic signed [SB-1:0] cur_reg, cur_next;
    logic                 last_reg, last_next;
    logic signed [SB-1:0] prev_reg, prev_next;
    logic                 have_prev_reg, have_prev_next;
    logic [SKIP_W-1:0]    skip_reg, skip_next;
    logic [PHASE_W-1:0]   rem_reg, rem_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [SB-1:0]        pend_val_reg, pend_val_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [SB-1:0]        hold_val_reg, hold_val_next;

    logic signed [NUM_W-1:0] acc_reg, acc_next;
    logic                 neg_reg, neg_next;
    logic [PHASE_W-1:0]   part_reg, part_next;
    logic [SB-1:0]        quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [RATE_W-1:0]    r_reg, r_next;
    logic                 tail_reg, tail_next;

    logic                 m_valid_reg, m_valid_next;
    logic [SB-1:0]        m_sample_reg, m_sample_next;
    logic                 m_run_last_reg, m_run_last_next;
    logic                 m_stream_end_reg, m_stream_end_next;

    logic [RATE_W-1:0]    src_eff;
    logic [PHASE_W-1:0]   tgt;
    logic [PHASE_W-1:0]   w_left;
    logic signed [SB:0]   pair_sum;
    logic signed [SB-1:0] mono;
    logic signed [SB-1:0] mul_a;
    logic signed [15:0]   mul_b;
    logic signed [NUM_W-1:0] prod;
    logic [NUM_W-1:0]     mag;
    logic [PHASE_W:0]     div_trial;
    logic [SB-1:0]        interp_val;
    logic                 out_free;
    logic                 can_put;
    sub_req_t             sub_req;
    sub_res_t             sub_res;

    mlr_sub_unit u_sub (
        .req (sub_req),
        .res (sub_res)
    );

    assign src_eff = (src_reg < RATE_MIN) ? RATE_MIN :
                     (src_reg > RATE_MAX) ? RATE_MAX : src_reg;
    assign tgt     = tsel_reg ? TGT_HI : TGT_LO;
    assign w_left  = tgt - rem_reg;

    // Floor of half the sum is an arithmetic shift of the widened sum.
    assign pair_sum = {s_left_sample[SB-1], s_left_sample}
                    + {s_right_sample[SB-1], s_right_sample};
    assign mono     = stereo_reg ? pair_sum[SB:1] : s_left_sample;

    assign mul_a = (state_reg == ST_MUL1) ? prev_reg : cur_reg;
    assign mul_b = (state_reg == ST_MUL1) ? $signed({1'b0, w_left})
                                          : $signed({1'b0, rem_reg});
    assign prod  = mul_a * mul_b;

    assign mag        = acc_reg[NUM_W-1] ? NUM_W'(-acc_reg) : NUM_W'(acc_reg);
    assign div_trial  = {part_reg, quo_reg[SB-1]};
    assign interp_val = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    assign sub_req.a = (state_reg == ST_DIV) ? SUB_W'(div_trial) : r_reg;
    assign sub_req.b = SUB_W'(tgt);

    assign out_free = !m_valid_reg || m_ready;
    assign can_put  = !hold_valid_reg || out_free;

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_sample_reg;
    assign m_run_last   = m_run_last_reg;
    assign m_stream_end = m_stream_end_reg;

    always_comb begin
        state_next        = state_reg;
        src_next          = src_reg;
        tsel_next         = tsel_reg;
        stereo_next       = stereo_reg;
        cur_next          = cur_reg;
        last_next         = last_reg;
        prev_next         = prev_reg;
        have_prev_next    = have_prev_reg;
        skip_next         = skip_reg;
        rem_next          = rem_reg;
        pend_valid_next   = pend_valid_reg;
        pend_val_next     = pend_val_reg;
        hold_valid_next   = hold_valid_reg;
        hold_val_next     = hold_val_reg;
        acc_next          = acc_reg;
        neg_next          = neg_reg;
        part_next         = part_reg;
        quo_next          = quo_reg;
        cnt_next          = cnt_reg;
        r_next            = r_reg;
        tail_next         = tail_reg;
        m_valid_next      = m_valid_reg;
        m_sample_next     = m_sample_reg;
        m_run_last_next   = m_run_last_reg;
        m_stream_end_next = m_stream_end_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                CFG_SOURCE_RATE:   src_next    = cfg_data[RATE_W-1:0];
                CFG_TARGET_SELECT: tsel_next   = cfg_data[0];
                CFG_STEREO_MODE:   stereo_next = cfg_data[0];
                default: ;
            endcase
        end

        // A new result word always parks in the hold register first, so the
        // last word of a frame can still be marked when the frame finishes.
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cur_next   = mono;
                    last_next  = s_stream_last;
                    state_next = have_prev_reg ? ST_PEND : ST_UPD;
                end
            end
            ST_PEND: begin
                if (pend_valid_reg && confirmed(skip_reg, rem_reg, 4'd2)) begin
                    if (can_put) begin
                        if (hold_valid_reg) begin
                            m_valid_next      = 1'b1;
                            m_sample_next     = hold_val_reg;
                            m_run_last_next   = 1'b0;
                            m_stream_end_next = 1'b0;
                        end
                        hold_val_next   = pend_val_reg;
                        hold_valid_next = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_LOOP;
                    end
                end else begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP: begin
                if (skip_reg == '0) begin
                    state_next = ST_MUL1;
                end else begin
                    skip_next  = skip_reg - 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_MUL1: begin
                acc_next   = prod;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                acc_next   = acc_reg + prod;
                state_next = ST_DSET;
            end
            ST_DSET: begin
                neg_next   = acc_reg[NUM_W-1];
                part_next  = mag[SB+PHASE_W-1:SB];
                quo_next   = mag[SB-1:0];
                cnt_next   = CNT_W'(SB - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                part_next = sub_res.ge ? sub_res.diff[PHASE_W-1:0]
                                       : div_trial[PHASE_W-1:0];
                quo_next  = {quo_reg[SB-2:0], sub_res.ge};
                if (cnt_reg == '0) begin
                    tail_next  = 1'b0;
                    state_next = ST_ADV0;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_ADV0: begin
                r_next     = src_eff + RATE_W'(rem_reg);
                state_next = ST_ADV1;
            end
            ST_ADV1: begin
                if (sub_res.ge) begin
                    r_next = sub_res.diff[RATE_W-1:0];
                    if (skip_reg != SKIP_MAX) begin
                        skip_next = skip_reg + 1'b1;
                    end
                end else begin
                    rem_next   = r_reg[PHASE_W-1:0];
                    state_next = tail_reg ? ST_LPLACE : ST_PLACE;
                end
            end
            ST_PLACE: begin
                if (confirmed(skip_reg, rem_reg, 4'd2)) begin
                    if (can_put) begin
                        if (hold_valid_reg) begin
                            m_valid_next      = 1'b1;
                            m_sample_next     = hold_val_reg;
                            m_run_last_next   = 1'b0;
                            m_stream_end_next = 1'b0;
                        end
                        hold_val_next   = interp_val;
                        hold_valid_next = 1'b1;
                        state_next      = ST_LOOP;
                    end
                end else begin
                    // Kept back until a later frame shows it is inside the stream.
                    pend_val_next   = interp_val;
                    pend_valid_next = 1'b1;
                    state_next      = ST_LOOP;
                end
            end
            ST_UPD: begin
                prev_next      = cur_reg;
                have_prev_next = 1'b1;
                state_next     = last_reg ? ST_LPEND : ST_FIN;
            end
            ST_LPEND: begin
                if (pend_valid_reg && confirmed(skip_reg, rem_reg, 4'd1)) begin
                    if (can_put) begin
                        if (hold_valid_reg) begin
                            m_valid_next      = 1'b1;
                            m_sample_next     = hold_val_reg;
                            m_run_last_next   = 1'b0;
                            m_stream_end_next = 1'b0;
                        end
                        hold_val_next   = pend_val_reg;
                        hold_valid_next = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_LLOOP;
                    end
                end else begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_LLOOP;
                end
            end
            ST_LLOOP: begin
                if (skip_reg == '0) begin
                    tail_next  = 1'b1;
                    state_next = ST_ADV0;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_LPLACE: begin
                if (confirmed(skip_reg, rem_reg, 4'd1)) begin
                    if (can_put) begin
                        if (hold_valid_reg) begin
                            m_valid_next      = 1'b1;
                            m_sample_next     = hold_val_reg;
                            m_run_last_next   = 1'b0;
                            m_stream_end_next = 1'b0;
                        end
                        hold_val_next   = cur_reg;
                        hold_valid_next = 1'b1;
                        state_next      = ST_LLOOP;
                    end
                end else begin
                    state_next = ST_LLOOP;
                end
            end
            ST_FIN: begin
                if (!hold_valid_reg || out_free) begin
                    if (hold_valid_reg) begin
                        m_valid_next      = 1'b1;
                        m_sample_next     = hold_val_reg;
                        m_run_last_next   = 1'b1;
                        m_stream_end_next = last_reg;
                        hold_valid_next   = 1'b0;
                    end
                    if (last_reg) begin
                        prev_next       = '0;
                        have_prev_next  = 1'b0;
                        skip_next       = '0;
                        rem_next        = '0;
                        pend_valid_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            src_reg        <= RATE_RESET;
            tsel_reg       <= 1'b0;
            stereo_reg     <= 1'b1;
            have_prev_reg  <= 1'b0;
            skip_reg       <= '0;
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            tail_reg       <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            src_reg        <= src_next;
            tsel_reg       <= tsel_next;
            stereo_reg     <= stereo_next;
            have_prev_reg  <= have_prev_next;
            skip_reg       <= skip_next;
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
            tail_reg       <= tail_next;
            cnt_reg        <= cnt_next;
        end
        cur_reg          <= cur_next;
        last_reg         <= last_next;
        prev_reg         <= prev_next;
        pend_val_reg     <= pend_val_next;
        hold_val_reg     <= hold_val_next;
        acc_reg          <= acc_next;
        neg_reg          <= neg_next;
        part_reg         <= part_next;
        quo_reg          <= quo_next;
        r_reg            <= r_next;
        m_sample_reg     <= m_sample_next;
        m_run_last_reg   <= m_run_last_next;
        m_stream_end_reg <= m_stream_end_next;
    end

endmodule

FILE: hdl/mlr_checker.sv
// ---------------------------------------------------------------------------
// Mono linear resampler port checker
// Watches the top-level ports and flags sequences the core must never show.
// ---------------------------------------------------------------------------
module mlr_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [SAMPLE_BITS-1:0] m_out_sample,
    input logic                   m_run_last,
    input logic                   m_stream_end
);

    // A stalled result word keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_sample)
            && $stable(m_run_last) && $stable(m_stream_end))
        else $error("result word changed while stalled");

    // The end of a stream is always the last word of its frame.
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_end |-> m_run_last)
        else $error("stream end without run last");

    // Only one frame is in work at a time.
    a_one_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again before the frame finished");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind mono_linear_resampler_core mlr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mlr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_sample (m_out_sample),
    .m_run_last   (m_run_last),
    .m_stream_end (m_stream_end)
);
